[hw/rtl/bra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg - shared types and constants for the bitmap range allocator
// Request and result layouts, operation codes, widths and defaults.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int POS_W         = 11;
	localparam int ALIGN_W       = 10;
	localparam int OP_W          = 2;
	localparam int MAP_BITS_DEF  = 1024;
	localparam int WORD_BITS_DEF = 64;
	localparam int AREA_RESET    = 1024;

	typedef enum logic [OP_W-1:0] {
		OP_FIND  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   start_bit;
		logic [POS_W-1:0]   bit_count;
		logic [ALIGN_W-1:0] round_mask;
	} request_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/bra_word_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_word_mem - occupancy word store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bra_word_mem #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bra_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ctrl - word sequencer for search and range writes
// Walks the bitmap a word at a time: zero-area search with restart on an
// occupied bit, read-modify-write for set and clear, clearing pass at reset.
// ----------------------------------------------------------------------------
module bra_ctrl #(
	parameter  int MAP_BITS  = 1024,
	parameter  int WORD_BITS = 64,
	localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS,
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire bra_pkg::request_t    request,
	input  wire logic [10:0]          area_size,
	output      logic                 done,
	output      bra_pkg::result_t     result,
	output      logic                 wr_en,
	output      logic [ADDR_W-1:0]    wr_addr,
	output      logic [WORD_BITS-1:0] wr_data,
	output      logic                 rd_en,
	output      logic [ADDR_W-1:0]    rd_addr,
	input  wire logic [WORD_BITS-1:0] rd_data
);
	import bra_pkg::*;

	// positions, range ends and word bases all stay below 2^EW
	localparam int EW      = POS_W + 2;
	localparam int OW      = $clog2(WORD_BITS + 1);
	localparam int LW      = $clog2(WORD_BITS);
	localparam int DIV_SH  = EW + LW;
	localparam int PROD_W  = EW + DIV_SH + 1;
	localparam int DIV_RCP = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_F_CHECK,
		ST_F_BASE,
		ST_F_SCAN,
		ST_W_BASE,
		ST_W_RMW
	} state_t;

	function automatic logic [ADDR_W-1:0] word_of(input logic [EW-1:0] q);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(q) * PROD_W'(DIV_RCP);
		return ADDR_W'(prod >> DIV_SH);
	endfunction

	function automatic logic [EW-1:0] align_up(input logic [EW-1:0] x,
	                                          input logic [ALIGN_W-1:0] m);
		logic [EW-1:0] mx;
		mx = EW'(m);
		return (x + mx) & ~mx;
	endfunction

	state_t               state_q, state_d;
	logic                 done_q, done_d;
	result_t              result_q, result_d;
	logic [ADDR_W-1:0]    clr_q;

	logic [EW-1:0]        p_q, p_d;
	logic [EW-1:0]        b_q, b_d;
	logic [EW-1:0]        end_q, end_d;
	logic [EW-1:0]        base_q, base_d;
	logic [ADDR_W-1:0]    widx_q, widx_d;
	logic [POS_W-1:0]     nr_q, nr_d;
	logic [ALIGN_W-1:0]   m_q, m_d;
	logic [POS_W-1:0]     size_q, size_d;
	logic [POS_W-1:0]     start_q, start_d;
	logic                 set_q, set_d;

	logic                 accept;
	logic [POS_W-1:0]     size_clip;
	logic [EW-1:0]        range_sum;
	logic [EW-1:0]        range_end;
	logic [EW-1:0]        p_end;
	logic [EW-1:0]        base_end;
	logic                 last_word;
	logic [OW-1:0]        lo;
	logic [OW-1:0]        hi;
	logic [WORD_BITS-1:0] win;
	logic [WORD_BITS-1:0] hits;
	logic [LW-1:0]        first;
	logic [EW-1:0]        restart;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign size_clip = (32'(area_size) > MAP_BITS) ? POS_W'(MAP_BITS) : area_size;
	assign range_sum = EW'(request.start_bit) + EW'(request.bit_count);
	assign range_end = (32'(range_sum) > MAP_BITS) ? EW'(MAP_BITS) : range_sum;
	assign p_end     = p_q + EW'(nr_q);

	// window of the current word
	assign base_end  = base_q + EW'(WORD_BITS);
	assign last_word = (end_q <= base_end);
	assign lo        = OW'(b_q - base_q);
	assign hi        = last_word ? OW'(end_q - base_q) : OW'(WORD_BITS);

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			win[i] = (OW'(i) >= lo) && (OW'(i) < hi);
		end
	end

	assign hits = rd_data & win;

	always_comb begin
		first = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hits[i]) begin
				first = LW'(i);
			end
		end
	end

	assign restart = align_up(base_q + EW'(first) + EW'(1), m_q);

	always_comb begin
		state_d  = state_q;
		done_d   = 1'b0;
		result_d = result_q;
		p_d      = p_q;
		b_d      = b_q;
		end_d    = end_q;
		base_d   = base_q;
		widx_d   = widx_q;
		nr_d     = nr_q;
		m_d      = m_q;
		size_d   = size_q;
		start_d  = start_q;
		set_d    = set_q;
		wr_en    = 1'b0;
		wr_addr  = widx_q;
		wr_data  = '0;
		rd_en    = 1'b0;
		rd_addr  = widx_q;

		unique case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == ADDR_W'(NUM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					start_d = request.start_bit;
					nr_d    = request.bit_count;
					m_d     = request.round_mask;
					size_d  = size_clip;
					set_d   = (request.op == OP_SET);
					b_d     = EW'(request.start_bit);
					end_d   = range_end;
					widx_d  = word_of(EW'(request.start_bit));
					unique case (request.op)
						OP_FIND: begin
							p_d     = align_up(EW'(request.start_bit), request.round_mask);
							state_d = ST_F_CHECK;
						end
						OP_SET, OP_CLEAR: begin
							if (EW'(request.start_bit) >= range_end) begin
								done_d   = 1'b1;
								result_d = '{position: request.start_bit, found: 1'b1};
							end else begin
								state_d = ST_W_BASE;
							end
						end
						default: begin
							done_d   = 1'b1;
							result_d = '{position: request.start_bit, found: 1'b0};
						end
					endcase
				end
			end
			ST_F_CHECK: begin
				if (p_end > EW'(size_q)) begin
					done_d   = 1'b1;
					result_d = '{position: size_q, found: 1'b0};
					state_d  = ST_IDLE;
				end else if (nr_q == '0) begin
					done_d   = 1'b1;
					result_d = '{position: POS_W'(p_q), found: 1'b1};
					state_d  = ST_IDLE;
				end else begin
					widx_d  = word_of(p_q);
					end_d   = p_end;
					b_d     = p_q;
					state_d = ST_F_BASE;
				end
			end
			ST_F_BASE, ST_W_BASE: begin
				base_d  = EW'(32'(widx_q) * 32'(WORD_BITS));
				rd_en   = 1'b1;
				state_d = (state_q == ST_F_BASE) ? ST_F_SCAN : ST_W_RMW;
			end
			ST_F_SCAN: begin
				if (|hits) begin
					p_d     = restart;
					state_d = ST_F_CHECK;
				end else if (last_word) begin
					done_d   = 1'b1;
					result_d = '{position: POS_W'(p_q), found: 1'b1};
					state_d  = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = widx_q + ADDR_W'(1);
					widx_d  = widx_q + ADDR_W'(1);
					base_d  = base_end;
					b_d     = base_end;
				end
			end
			ST_W_RMW: begin
				wr_en   = 1'b1;
				wr_data = set_q ? (rd_data | win) : (rd_data & ~win);
				if (last_word) begin
					done_d   = 1'b1;
					result_d = '{position: start_q, found: 1'b1};
					state_d  = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = widx_q + ADDR_W'(1);
					widx_d  = widx_q + ADDR_W'(1);
					base_d  = base_end;
					b_d     = base_end;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			done_q   <= 1'b0;
			result_q <= '0;
			clr_q    <= '0;
		end else begin
			state_q  <= state_d;
			done_q   <= done_d;
			result_q <= result_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q     <= p_d;
		b_q     <= b_d;
		end_q   <= end_d;
		base_q  <= base_d;
		widx_q  <= widx_d;
		nr_q    <= nr_d;
		m_q     <= m_d;
		size_q  <= size_d;
		start_q <= start_d;
		set_q   <= set_d;
	end

endmodule
`default_nettype wire

[hw/rtl/bitmap_range_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_range_allocator - occupancy bitmap with zero-area search
// Find, set and clear over a word-organised bitmap held in one memory.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------
//   request  | start, busy           | request (op, start, count, mask)
//   result   | done (one-cycle)      | result (position, found)
//   config   | cfg_valid, cfg_ready  | cfg_data (area size)
//
// Set/clear: one read-modify-write per word touched by the range.
// Find: each attempt scans the words under the candidate area; each occupied
// bit hit starts a new attempt, aligned up past that bit.
// After reset every memory word is zeroed while busy is high.
// Results cannot be stalled; a new request may start while a result shows.
// ----------------------------------------------------------------------------
module bitmap_range_allocator #(
	parameter int MAP_BITS  = bra_pkg::MAP_BITS_DEF,
	parameter int WORD_BITS = bra_pkg::WORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic [10:0]       cfg_data,
	input  wire logic              start,
	output      logic              busy,
	input  wire bra_pkg::request_t request,
	output      logic              done,
	output      bra_pkg::result_t  result
);
	import bra_pkg::*;

	localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	logic [POS_W-1:0]     area_size_q;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_size_q <= POS_W'(AREA_RESET);
		end else if (cfg_valid && cfg_ready) begin
			area_size_q <= cfg_data;
		end
	end

	bra_ctrl #(
		.MAP_BITS  (MAP_BITS),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.area_size (area_size_q),
		.done      (done),
		.result    (result),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	bra_word_mem #(
		.DATA_W (WORD_BITS),
		.DEPTH  (NUM_WORDS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
`default_nettype wire

[tb/sv/tb_bitmap_range_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_range_allocator - self-checking bench for the bitmap allocator
// Drives find, set, clear and unsupported requests, plus area size writes, and
// checks each result against an in-bench bitmap predictor. A directed part
// covers field extremes, alignment, clipping at the map end and area limits.
// Random allocate/free traffic and noise follow, under several idle mixes.
// ----------------------------------------------------------------------------
module tb_bitmap_range_allocator;
	import bra_pkg::*;

	localparam int          MAP_BITS    = MAP_BITS_DEF;
	localparam int          STALL_LIMIT = 50000;
	localparam logic [1:0]  OP_UNKNOWN  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	request_t    request = '0;
	logic        done;
	result_t     result;

	bitmap_range_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [MAP_BITS-1:0] occ_map = '0;
	int unsigned         area_cfg = AREA_RESET;
	result_t             expected_q[$];

	int errors;
	int n_items, n_hits, n_misses, n_writes, n_unknown, n_area_writes;
	int idle_pct;
	int unsigned held_pos[$], held_len[$];

	function automatic int unsigned round_up(int unsigned x, int unsigned m);
		return (x + m) & ~m;
	endfunction

	// outcome of one request; set/clear update the predicted bitmap
	function automatic result_t alloc_outcome(request_t rq);
		result_t     r;
		int unsigned size, p, b, n, m, lim;
		logic        hit;
		r.position = rq.start_bit;
		r.found    = 1'b0;
		case (rq.op)
			OP_FIND: begin
				size = (area_cfg > MAP_BITS) ? MAP_BITS : area_cfg;
				n    = rq.bit_count;
				m    = rq.round_mask;
				p    = round_up(rq.start_bit, m);
				b    = p;
				hit  = 1'b0;
				while (!hit && p + n <= size) begin
					if (b - p == n) begin
						hit = 1'b1;
					end else if (b < MAP_BITS && occ_map[b]) begin
						p = round_up(b + 1, m);
						b = p;
					end else begin
						b++;
					end
				end
				r.found    = hit;
				r.position = hit ? POS_W'(p) : POS_W'(size);
			end
			OP_SET, OP_CLEAR: begin
				lim = rq.start_bit + rq.bit_count;
				if (lim > MAP_BITS)
					lim = MAP_BITS;
				for (b = rq.start_bit; b < lim; b++)
					occ_map[b] = (rq.op == OP_SET);
				r.found = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < 40)
			$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with none pending, position", result.position, 0);
			end else begin
				want = expected_q.pop_front();
				if (result.position !== want.position)
					report_mismatch("position", result.position, want.position);
				if (result.found !== want.found)
					report_mismatch("found", result.found, want.found);
			end
		end
	end

	// watchdog: cycles with no handshake of any kind
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress, %0d results outstanding", expected_q.size());
			$display("tb_bitmap_range_allocator: done, errors");
			$finish;
		end
	end

	// returns just after the accepting edge with start still high
	task automatic issue_request(input request_t rq, output result_t outcome);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		outcome = alloc_outcome(rq);
		expected_q.push_back(outcome);
		n_items++;
		if (rq.op == OP_FIND) begin
			if (outcome.found) n_hits++;
			else n_misses++;
		end else if (rq.op == OP_UNKNOWN) begin
			n_unknown++;
		end else begin
			n_writes++;
		end
	endtask

	task automatic send(input logic [1:0] op, input int unsigned sb, input int unsigned cnt,
			input int unsigned mask);
		request_t rq;
		result_t  r;
		rq.op         = op;
		rq.start_bit  = POS_W'(sb);
		rq.bit_count  = POS_W'(cnt);
		rq.round_mask = ALIGN_W'(mask);
		issue_request(rq, r);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_area(input int unsigned value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= 11'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		area_cfg = value & 32'h7FF;
		n_area_writes++;
	endtask

	function automatic int unsigned pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return $urandom_range(1, 16);
		if (r < 85) return $urandom_range(0, 128);
		if (r < 95) return $urandom_range(0, 1024);
		return $urandom_range(0, 2047);
	endfunction

	function automatic int unsigned pick_mask();
		if ($urandom_range(3) != 0)
			return (1 << $urandom_range(10)) - 1;
		return $urandom_range(1023);
	endfunction

	task automatic test_empty_map();
		idle_pct = 0;
		send(OP_FIND, 0, 0, 0);
		send(OP_FIND, 0, 1024, 0);
		send(OP_FIND, 0, 2047, 1023);
		send(OP_FIND, 1024, 0, 0);
		send(OP_FIND, 1025, 0, 0);
		send(OP_FIND, 3, 8, 63);
		send(OP_FIND, 5, 4, 5);
	endtask

	task automatic test_ranges();
		send(OP_SET, 0, 10, 0);
		send(OP_FIND, 0, 4, 0);
		send(OP_SET, 1000, 100, 0);
		send(OP_FIND, 900, 100, 0);
		send(OP_FIND, 990, 20, 0);
		send(OP_CLEAR, 0, 5, 0);
		send(OP_FIND, 0, 5, 0);
		send(OP_CLEAR, 2047, 2047, 0);
		send(OP_FIND, 1, 1, 1023);
	endtask

	task automatic test_unknown_op();
		send(OP_UNKNOWN, 2047, 2047, 1023);
		send(OP_UNKNOWN, 0, 1, 0);
		send(OP_FIND, 0, 5, 0);
		send(OP_CLEAR, 0, 2047, 0);
	endtask

	task automatic test_area_size();
		write_area(1);
		send(OP_FIND, 0, 1, 0);
		send(OP_FIND, 0, 2, 0);
		send(OP_FIND, 1, 0, 0);
		write_area(2047);
		send(OP_FIND, 0, 1024, 0);
		send(OP_FIND, 0, 1025, 0);
		write_area(AREA_RESET);
	endtask

	// allocate/free workload with random content, plus noise
	task automatic test_random_traffic(input int items, input int idle,
			input int unsigned area);
		int          goal, r, k;
		int unsigned n, sb;
		request_t    rq;
		result_t     res;
		write_area(area);
		idle_pct = idle;
		goal = n_items + items;
		while (n_items < goal) begin
			r = $urandom_range(99);
			if ($urandom_range(49) == 0)
				drain();
			if (r < 45) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(0, 256) : $urandom_range(1, 48);
				rq.op         = OP_FIND;
				rq.start_bit  = ($urandom_range(3) == 0) ? POS_W'($urandom_range(1024)) : '0;
				rq.bit_count  = POS_W'(n);
				rq.round_mask = ALIGN_W'(pick_mask());
				issue_request(rq, res);
				if (res.found && n != 0) begin
					send(OP_SET, res.position, n, 0);
					held_pos.push_back(res.position);
					held_len.push_back(n);
				end
			end else if (r < 75 && held_pos.size() != 0) begin
				k = $urandom_range(held_pos.size() - 1);
				send(OP_CLEAR, held_pos[k], held_len[k], 0);
				held_pos.delete(k);
				held_len.delete(k);
			end else begin
				sb = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1024);
				send(2'($urandom_range(3)), sb, pick_count(), pick_mask());
			end
		end
	endtask

	initial begin
		errors = 0;
		n_items = 0; n_hits = 0; n_misses = 0; n_writes = 0; n_unknown = 0;
		n_area_writes = 0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_map();
		test_ranges();
		test_unknown_op();
		test_area_size();
		test_random_traffic(250, 0, 1024);
		test_random_traffic(200, 83, $urandom_range(64, 1024));
		test_random_traffic(200, 8, 2047);
		test_random_traffic(180, 0, $urandom_range(1, 1024));

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d requests: %0d finds hit, %0d missed, %0d set/clear, %0d unsupported",
			n_items, n_hits, n_misses, n_writes, n_unknown);
		$display("area size written %0d times, %0d mismatches", n_area_writes, errors);
		if (errors == 0)
			$display("tb_bitmap_range_allocator: done, clean");
		else
			$display("tb_bitmap_range_allocator: done, errors");
		$finish;
	end

endmodule

[files.f]
hw/rtl/bra_pkg.sv
hw/rtl/bra_word_mem.sv
hw/rtl/bra_ctrl.sv
hw/rtl/bitmap_range_allocator.sv
tb/sv/tb_bitmap_range_allocator.sv
